@@ rtl/sjrq_pkg.sv @@
// ----------------------------------------------------------------------------
// Shortest-job ready queue package
// Types, codes and defaults shared by the ready queue core and its checker.
// ----------------------------------------------------------------------------
package sjrq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int BURST_W  = 16;
   localparam int TAG_W    = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_SCAN,
      SQ_PLACE,
      SQ_POP
   } seq_state_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [TAG_W-1:0]   tag;
   } entry_type;

endpackage

@@ rtl/sjrq_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries insert and pop requests.
// ----------------------------------------------------------------------------
interface sjrq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [sjrq_pkg::BURST_W-1:0] task_burst;
   logic [sjrq_pkg::TAG_W-1:0]   task_tag;

   modport source (output valid, output kind, output task_burst, output task_tag,
                   input ready);
   modport sink   (input valid, input kind, input task_burst, input task_tag,
                   output ready);
endinterface

@@ rtl/sjrq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one status beat for each request.
// ----------------------------------------------------------------------------
interface sjrq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sjrq_pkg::STATUS_W-1:0] status;
   logic [sjrq_pkg::TAG_W-1:0]    popped_tag;
   logic [sjrq_pkg::BURST_W-1:0]  popped_burst;
   logic [sjrq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output popped_tag,
                   output popped_burst, output occupancy, input ready);
   modport sink   (input valid, input status, input popped_tag,
                   input popped_burst, input occupancy, output ready);
endinterface

@@ rtl/sjrq_store.sv @@
// ----------------------------------------------------------------------------
// Ready queue entry store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module sjrq_store #(
   parameter int QUEUE_DEPTH = sjrq_pkg::DEFAULT_QUEUE_DEPTH,
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  sjrq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output sjrq_pkg::entry_type rd_data
);

   sjrq_pkg::entry_type mem_ff [QUEUE_DEPTH];
   sjrq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/shortest_job_ready_queue_core.sv @@
// ----------------------------------------------------------------------------
// Shortest-job ready queue core
// Bounded ready queue kept sorted by burst time, held as a ring in memory.
// ----------------------------------------------------------------------------
// A pop reads the head entry from memory and loads it into the response
// register from the SQ_POP state. An insert into a non-empty queue walks the
// queue from its tail towards the head with one memory read, one burst compare
// and one memory write per cycle, moving each queued entry with a larger burst
// up by one place before it writes the new entry. Inserts into an empty queue,
// inserts into a full queue and pops from an empty queue load the response
// register straight from the idle state. The request side is ready again
// once the sequencer is idle and the response register is free or being
// emptied.
module shortest_job_ready_queue_core #(
   parameter int QUEUE_DEPTH = sjrq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   sjrq_req_if.sink   req_if,
   sjrq_rsp_if.source rsp_if
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sjrq_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   sjrq_pkg::entry_type          key_ff, key_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   sjrq_pkg::status_type          status_ff, status_in;
   logic [sjrq_pkg::TAG_W-1:0]    ptag_ff, ptag_in;
   logic [sjrq_pkg::BURST_W-1:0]  pburst_ff, pburst_in;
   logic [sjrq_pkg::OCC_W-1:0]    occ_ff, occ_in;

   logic                req_accept;
   logic                rsp_load;
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_lidx, rd_lidx;
   sjrq_pkg::entry_type wr_data, rd_data;

   function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] lidx);
      logic [IDX_W:0] sum;
      sum = (IDX_W+1)'(head) + (IDX_W+1)'(lidx);
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   sjrq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ring_idx(head_ff, wr_lidx)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ring_idx(head_ff, rd_lidx)),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == sjrq_pkg::SQ_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sjrq_pkg::SQ_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      ptag_ff   <= ptag_in;
      pburst_ff <= pburst_in;
      occ_ff    <= occ_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      status_in = status_ff;
      ptag_in   = ptag_ff;
      pburst_in = pburst_ff;
      occ_in    = occ_ff;
      rsp_load  = 1'b0;
      wr_en     = 1'b0;
      wr_lidx   = '0;
      wr_data   = key_ff;
      rd_en     = 1'b0;
      rd_lidx   = '0;

      unique case (state_ff)
         sjrq_pkg::SQ_IDLE: begin
            if (req_accept) begin
               key_in.burst = req_if.task_burst;
               key_in.tag   = req_if.task_tag;
               ptag_in      = '0;
               pburst_in    = '0;
               if (req_if.kind == sjrq_pkg::KIND_POP) begin
                  if (count_ff == '0) begin
                     rsp_load  = 1'b1;
                     status_in = sjrq_pkg::ST_EMPTY;
                     occ_in    = sjrq_pkg::OCC_W'(count_ff);
                  end else begin
                     rd_en    = 1'b1;
                     rd_lidx  = '0;
                     state_in = sjrq_pkg::SQ_POP;
                  end
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_load  = 1'b1;
                  status_in = sjrq_pkg::ST_FULL;
                  occ_in    = sjrq_pkg::OCC_W'(count_ff);
               end else if (count_ff == '0) begin
                  wr_en         = 1'b1;
                  wr_lidx       = '0;
                  wr_data.burst = req_if.task_burst;
                  wr_data.tag   = req_if.task_tag;
                  count_in      = CNT_W'(1);
                  rsp_load      = 1'b1;
                  status_in     = sjrq_pkg::ST_DONE;
                  occ_in        = sjrq_pkg::OCC_W'(1);
               end else begin
                  rd_en    = 1'b1;
                  rd_lidx  = IDX_W'(count_ff - CNT_W'(1));
                  pos_in   = IDX_W'(count_ff - CNT_W'(1));
                  state_in = sjrq_pkg::SQ_SCAN;
               end
            end
         end
         sjrq_pkg::SQ_SCAN: begin
            wr_en   = 1'b1;
            wr_lidx = pos_ff + IDX_W'(1);
            if (rd_data.burst > key_ff.burst) begin
               wr_data = rd_data;
               if (pos_ff == '0) begin
                  state_in = sjrq_pkg::SQ_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_lidx = pos_ff - IDX_W'(1);
                  pos_in  = pos_ff - IDX_W'(1);
               end
            end else begin
               wr_data   = key_ff;
               count_in  = count_ff + CNT_W'(1);
               rsp_load  = 1'b1;
               status_in = sjrq_pkg::ST_DONE;
               occ_in    = sjrq_pkg::OCC_W'(count_ff + CNT_W'(1));
               state_in  = sjrq_pkg::SQ_IDLE;
            end
         end
         sjrq_pkg::SQ_PLACE: begin
            wr_en     = 1'b1;
            wr_lidx   = '0;
            wr_data   = key_ff;
            count_in  = count_ff + CNT_W'(1);
            rsp_load  = 1'b1;
            status_in = sjrq_pkg::ST_DONE;
            occ_in    = sjrq_pkg::OCC_W'(count_ff + CNT_W'(1));
            state_in  = sjrq_pkg::SQ_IDLE;
         end
         sjrq_pkg::SQ_POP: begin
            head_in   = ring_idx(head_ff, IDX_W'(1));
            count_in  = count_ff - CNT_W'(1);
            rsp_load  = 1'b1;
            status_in = sjrq_pkg::ST_DONE;
            ptag_in   = rd_data.tag;
            pburst_in = rd_data.burst;
            occ_in    = sjrq_pkg::OCC_W'(count_ff - CNT_W'(1));
            state_in  = sjrq_pkg::SQ_IDLE;
         end
         default: begin
            state_in = sjrq_pkg::SQ_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.popped_tag   = ptag_ff;
   assign rsp_if.popped_burst = pburst_ff;
   assign rsp_if.occupancy    = occ_ff;

endmodule

@@ rtl/sjrq_checker.sv @@
// ----------------------------------------------------------------------------
// Shortest-job ready queue checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
module sjrq_assertions #(
   parameter int QUEUE_DEPTH = sjrq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sjrq_pkg::STATUS_W-1:0] rsp_status,
   input logic [sjrq_pkg::TAG_W-1:0]    rsp_popped_tag,
   input logic [sjrq_pkg::BURST_W-1:0]  rsp_popped_burst,
   input logic [sjrq_pkg::OCC_W-1:0]    rsp_occupancy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_tag) && $stable(rsp_popped_burst)
         && $stable(rsp_occupancy))
      else $error("Stalled response beat changed.");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sjrq_pkg::ST_FULL |->
         rsp_occupancy == sjrq_pkg::OCC_W'(QUEUE_DEPTH)
         && rsp_popped_tag == '0 && rsp_popped_burst == '0)
      else $error("Queue full response with wrong occupancy or pop fields.");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sjrq_pkg::ST_EMPTY |->
         rsp_occupancy == '0 && rsp_popped_tag == '0 && rsp_popped_burst == '0)
      else $error("Queue empty response with non-zero fields.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("Response valid straight after reset.");

endmodule

bind shortest_job_ready_queue_core sjrq_assertions #(.QUEUE_DEPTH(QUEUE_DEPTH))
   u_sjrq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_popped_tag   (rsp_if.popped_tag),
   .rsp_popped_burst (rsp_if.popped_burst),
   .rsp_occupancy    (rsp_if.occupancy)
);
